FILE: sv/button_edge_toggle_hold_classifier_defines.svh
// ----------------------------------------------------------------------------
// Assertion macros for the button edge, toggle and hold classifier
// Each macro expects clk and rst_n in the scope where it is used.
// ----------------------------------------------------------------------------
`ifndef BUTTON_EDGE_TOGGLE_HOLD_CLASSIFIER_DEFINES_SVH
`define BUTTON_EDGE_TOGGLE_HOLD_CLASSIFIER_DEFINES_SVH

// Consequent checked in the same cycle as the antecedent
`define BETHC_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequent checked in the cycle after the antecedent
`define BETHC_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: sv/bethc_pkg.sv
// ----------------------------------------------------------------------------
// bethc_pkg
// Types, widths and codes shared by the classifier modules.
// ----------------------------------------------------------------------------
`default_nettype none

package bethc_pkg;

    localparam int MAX_INTERVALS = 6;
    localparam int THR_W         = 16;
    localparam int ELAPSED_W     = 17;
    localparam int IDX_W         = 3;
    localparam int CFG_IDX_W     = 3;
    localparam int CFG_DATA_W    = 16;

    localparam logic [CFG_IDX_W-1:0] CFG_TOGGLE_MODE      = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_INTERVAL_COUNT   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_HOLD_THRESHOLD_0 = 3'd2;

    typedef enum logic [1:0] {
        EV_SET      = 2'd0,
        EV_CLEAR    = 2'd1,
        EV_TOGGLE   = 2'd2,
        EV_INTERVAL = 2'd3
    } event_kind_t;

    typedef enum logic [1:0] {
        TM_RISING  = 2'd0,
        TM_FALLING = 2'd1,
        TM_BOTH    = 2'd2,
        TM_RELEASE = 2'd3
    } toggle_mode_t;

    // controller -> datapath
    typedef struct packed {
        logic capture;
        logic edge_update;
        logic accumulate;
        logic emit_toggle;
        logic emit_interval;
    } bethc_cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic level_change;
        logic held_high;
        logic toggle;
        logic hit;
        logic hit_next;
    } bethc_status_t;

endpackage

`default_nettype wire

FILE: sv/bethc_in_if.sv
// ----------------------------------------------------------------------------
// bethc_in_if
// Input sample channel: level and ticks since the previous sample.
// ----------------------------------------------------------------------------
`default_nettype none

interface bethc_in_if import bethc_pkg::*;;
    logic             valid;
    logic             ready;
    logic             level;
    logic [THR_W-1:0] delta_ticks;

    modport source (output valid, output level, output delta_ticks, input ready);
    modport sink   (input valid, input level, input delta_ticks, output ready);
endinterface

`default_nettype wire

FILE: sv/bethc_out_if.sv
// ----------------------------------------------------------------------------
// bethc_out_if
// Event channel: kind, interval index and last-event mark.
// ----------------------------------------------------------------------------
`default_nettype none

interface bethc_out_if import bethc_pkg::*;;
    logic             valid;
    logic             ready;
    logic [1:0]       event_kind;
    logic [IDX_W-1:0] interval_number;
    logic             last_event;

    modport source (output valid, output event_kind, output interval_number,
                    output last_event, input ready);
    modport sink   (input valid, input event_kind, input interval_number,
                    input last_event, output ready);
endinterface

`default_nettype wire

FILE: sv/bethc_ctrl.sv
// ----------------------------------------------------------------------------
// bethc_ctrl
// Sequencer: takes one sample, steps through its events, owns output valid.
// ----------------------------------------------------------------------------
`default_nettype none

module bethc_ctrl import bethc_pkg::*; (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          in_valid,
    output logic               in_ready,
    output logic               out_valid,
    input  wire logic          out_ready,
    input  wire bethc_status_t status,
    output bethc_cmd_t         cmd
);

    typedef enum logic [3:0] {
        S_IDLE   = 4'b0001,
        S_PROC   = 4'b0010,
        S_TOGGLE = 4'b0100,
        S_SCAN   = 4'b1000
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   out_valid_reg;
    logic   out_valid_next;
    logic   out_free;
    logic   load;

    assign out_free = !out_valid_reg || out_ready;

    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        in_ready   = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.capture = 1'b1;
                    state_next  = S_PROC;
                end
            end
            S_PROC:
            begin
                if (status.level_change)
                begin
                    if (out_free)
                    begin
                        cmd.edge_update = 1'b1;
                        state_next      = status.toggle ? S_TOGGLE : S_IDLE;
                    end
                end
                else if (status.held_high)
                begin
                    cmd.accumulate = 1'b1;
                    state_next     = S_SCAN;
                end
                else
                begin
                    state_next = S_IDLE;
                end
            end
            S_TOGGLE:
            begin
                if (out_free)
                begin
                    cmd.emit_toggle = 1'b1;
                    state_next      = S_IDLE;
                end
            end
            S_SCAN:
            begin
                // one threshold per cycle while the output is free
                if (!status.hit)
                begin
                    state_next = S_IDLE;
                end
                else if (out_free)
                begin
                    cmd.emit_interval = 1'b1;
                    if (!status.hit_next)
                        state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign load = cmd.edge_update || cmd.emit_toggle || cmd.emit_interval;

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (load)
            out_valid_next = 1'b1;
        else if (out_ready)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid = out_valid_reg;

endmodule

`default_nettype wire

FILE: sv/bethc_datapath.sv
// ----------------------------------------------------------------------------
// bethc_datapath
// Configuration, level and hold timer state, threshold compares, output
// payload register.
// ----------------------------------------------------------------------------
`default_nettype none

module bethc_datapath import bethc_pkg::*; (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data,
    input  wire logic                  item_level,
    input  wire logic [THR_W-1:0]      item_delta,
    input  wire bethc_cmd_t            cmd,
    output bethc_status_t              status,
    output logic [1:0]                 event_kind,
    output logic [IDX_W-1:0]           interval_number,
    output logic                       last_event
);

    toggle_mode_t         mode_reg;
    logic [IDX_W-1:0]     count_reg;
    logic [THR_W-1:0]     thr_reg [MAX_INTERVALS];

    logic                 level_reg;
    logic [THR_W-1:0]     delta_reg;

    logic                 held_reg;
    logic                 held_next;
    logic [ELAPSED_W-1:0] elapsed_reg;
    logic [ELAPSED_W-1:0] elapsed_next;
    logic [IDX_W-1:0]     nti_reg;
    logic [IDX_W-1:0]     nti_next;
    logic                 pending_reg;
    logic                 pending_next;

    event_kind_t          kind_reg;
    logic [IDX_W-1:0]     num_reg;
    logic                 last_reg;

    logic [IDX_W-1:0]     used_cnt;
    logic [IDX_W:0]       nti_inc;
    logic [ELAPSED_W:0]   sum;
    logic [MAX_INTERVALS-1:0] over;
    logic                 over_cur;
    logic                 over_nxt;
    logic [IDX_W-1:0]     thr_sel;

    assign used_cnt = (count_reg > IDX_W'(MAX_INTERVALS)) ? IDX_W'(MAX_INTERVALS) : count_reg;
    assign nti_inc  = {1'b0, nti_reg} + 1'b1;
    assign sum      = {1'b0, elapsed_reg} + (ELAPSED_W+1)'(delta_reg);
    assign thr_sel  = cfg_index - CFG_HOLD_THRESHOLD_0;

    // each threshold has its own compare against the elapsed count
    always_comb
    begin
        over     = '0;
        over_cur = 1'b0;
        over_nxt = 1'b0;
        for (int k = 0; k < MAX_INTERVALS; k++)
        begin
            over[k] = {1'b0, thr_reg[k]} < elapsed_reg;
            if (nti_reg == IDX_W'(k))
                over_cur = over[k];
            if (nti_inc == (IDX_W+1)'(k))
                over_nxt = over[k];
        end
    end

    always_comb
    begin
        status.level_change = level_reg != held_reg;
        status.held_high    = held_reg;
        status.hit          = pending_reg && (nti_reg < used_cnt) && over_cur;
        status.hit_next     = (nti_inc < {1'b0, used_cnt}) && over_nxt;
        case (mode_reg)
            TM_RISING:  status.toggle = level_reg;
            TM_FALLING: status.toggle = !level_reg;
            TM_BOTH:    status.toggle = 1'b1;
            TM_RELEASE: status.toggle = !(level_reg && (used_cnt != '0)) && (nti_reg == '0);
            default:    status.toggle = 1'b0;
        endcase
    end

    always_comb
    begin
        held_next    = held_reg;
        elapsed_next = elapsed_reg;
        nti_next     = nti_reg;
        pending_next = pending_reg;
        if (cmd.edge_update)
        begin
            held_next = level_reg;
            // restart the hold timer on a press
            if (level_reg && (used_cnt != '0))
            begin
                elapsed_next = '0;
                nti_next     = '0;
                pending_next = 1'b1;
            end
        end
        if (cmd.accumulate)
            elapsed_next = sum[ELAPSED_W] ? '1 : sum[ELAPSED_W-1:0];
        if (cmd.emit_interval)
        begin
            nti_next = nti_inc[IDX_W-1:0];
            if (nti_inc >= {1'b0, used_cnt})
                pending_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg    <= TM_RISING;
            count_reg   <= '0;
            for (int k = 0; k < MAX_INTERVALS; k++)
                thr_reg[k] <= '0;
            held_reg    <= 1'b0;
            elapsed_reg <= '0;
            nti_reg     <= '0;
            pending_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    CFG_TOGGLE_MODE:    mode_reg  <= toggle_mode_t'(cfg_data[1:0]);
                    CFG_INTERVAL_COUNT: count_reg <= cfg_data[IDX_W-1:0];
                    default:            thr_reg[thr_sel] <= cfg_data[THR_W-1:0];
                endcase
            end
            held_reg    <= held_next;
            elapsed_reg <= elapsed_next;
            nti_reg     <= nti_next;
            pending_reg <= pending_next;
        end
    end

    // sample and payload registers
    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            level_reg <= item_level;
            delta_reg <= item_delta;
        end
        if (cmd.edge_update)
        begin
            kind_reg <= level_reg ? EV_SET : EV_CLEAR;
            num_reg  <= '0;
            last_reg <= !status.toggle;
        end
        else if (cmd.emit_toggle)
        begin
            kind_reg <= EV_TOGGLE;
            num_reg  <= '0;
            last_reg <= 1'b1;
        end
        else if (cmd.emit_interval)
        begin
            kind_reg <= EV_INTERVAL;
            num_reg  <= nti_reg;
            last_reg <= !status.hit_next;
        end
    end

    assign event_kind      = kind_reg;
    assign interval_number = num_reg;
    assign last_event      = last_reg;

endmodule

`default_nettype wire

FILE: sv/button_edge_toggle_hold_classifier.sv
// Flow: a sample is taken only in the idle state, so a new one waits for the last.
// A level change emits set or clear from the processing state, then a toggle event
// from the toggle state if the mode calls for one. A high sample with no change adds
// its delta to the hold timer; the scan state then emits one interval event per hold
// threshold reached (up to 6), one per cycle unless stalled; it takes longest.
// Reset: asynchronous, clears level, timer and all configuration to zero.
// ----------------------------------------------------------------------------
// button_edge_toggle_hold_classifier
// Turns sampled button levels into set, clear, toggle and hold-interval events.
// ----------------------------------------------------------------------------
`default_nettype none

module button_edge_toggle_hold_classifier import bethc_pkg::*; (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    bethc_in_if.sink                   in_ch,
    bethc_out_if.source                out_ch,
    input  wire logic                  cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data
);

    bethc_cmd_t    cmd;
    bethc_status_t status;

    bethc_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_ch.valid),
        .in_ready  (in_ch.ready),
        .out_valid (out_ch.valid),
        .out_ready (out_ch.ready),
        .status    (status),
        .cmd       (cmd)
    );

    bethc_datapath u_datapath (
        .clk             (clk),
        .rst_n           (rst_n),
        .cfg_we          (cfg_we),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .item_level      (in_ch.level),
        .item_delta      (in_ch.delta_ticks),
        .cmd             (cmd),
        .status          (status),
        .event_kind      (out_ch.event_kind),
        .interval_number (out_ch.interval_number),
        .last_event      (out_ch.last_event)
    );

endmodule

`default_nettype wire

FILE: sv/bethc_checker.sv
// ----------------------------------------------------------------------------
// bethc_checker
// Port-level checks on the classifier, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "button_edge_toggle_hold_classifier_defines.svh"

module bethc_checker import bethc_pkg::*; (
    input wire logic             clk,
    input wire logic             rst_n,
    input wire logic             in_valid,
    input wire logic             in_ready,
    input wire logic             out_valid,
    input wire logic             out_ready,
    input wire logic [1:0]       out_kind,
    input wire logic [IDX_W-1:0] out_number
);

    `BETHC_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid, "event dropped while stalled")
    `BETHC_ASSERT_NEXT(a_one_sample, in_valid && in_ready, !in_ready, "sample taken during processing")
    `BETHC_ASSERT_SAME(a_num_zero, out_valid && (out_kind != EV_INTERVAL), out_number == '0, "nonzero index on edge event")
    `BETHC_ASSERT_SAME(a_num_range, out_valid && (out_kind == EV_INTERVAL), out_number < IDX_W'(MAX_INTERVALS), "interval index out of range")

endmodule

bind button_edge_toggle_hold_classifier bethc_checker u_bethc_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_ch.valid),
    .in_ready   (in_ch.ready),
    .out_valid  (out_ch.valid),
    .out_ready  (out_ch.ready),
    .out_kind   (out_ch.event_kind),
    .out_number (out_ch.interval_number)
);

`default_nettype wire
